>>> rtl/hsvrgb_pkg.sv
// shared types, constants and sector codes for the hsv to rgb converter
package hsvrgb_pkg;

  localparam logic [8:0] HueMax    = 9'd360;
  localparam logic [8:0] SectorDeg = 9'd60;

  // floor(x / 60) for x up to 60*255 as (x * Recip60) >> Recip60Shift
  localparam int         Recip60Shift = 20;
  localparam logic [14:0] Recip60     = 15'd17477;

  // sector codes: first letter is the channel at full level, second the ramping one
  localparam logic [2:0] SEC_RG = 3'd0;
  localparam logic [2:0] SEC_GR = 3'd1;
  localparam logic [2:0] SEC_GB = 3'd2;
  localparam logic [2:0] SEC_BG = 3'd3;
  localparam logic [2:0] SEC_BR = 3'd4;
  localparam logic [2:0] SEC_RB = 3'd5;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [2:0] sector;
    logic [5:0] offset;
    logic [7:0] brightness;
    logic [7:0] spread;
  } front_t;

  typedef struct packed {
    logic [2:0] sector;
    logic [7:0] brightness;
    logic [7:0] base_level;
    logic [7:0] step;
  } ramp_t;

endpackage

>>> rtl/hsvrgb_if.sv
// stream interfaces for hsv pixels in and rgb pixels out
interface hsvrgb_hsv_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvrgb_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hsvrgb_front.sv
// first two pipeline stages: sector decode, sat*value product, spread = product/255
module hsvrgb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsvrgb_pkg::hsv_t    in_pix,
  output logic                out_valid,
  input  logic                out_ready,
  output hsvrgb_pkg::front_t  out_pix
);

  logic        valid1;
  logic        valid2;
  logic        adv1;
  logic        adv2;
  logic [2:0]  sector1;
  logic [5:0]  offset1;
  logic [7:0]  brightness1;
  logic [15:0] product1;
  logic [8:0]  hue_c;
  logic [2:0]  sector_next;
  logic [8:0]  offset_next;
  logic [16:0] prod_inc;
  logic [24:0] prod_scaled;
  hsvrgb_pkg::front_t stage2;

  assign adv2     = !valid2 || out_ready;
  assign adv1     = !valid1 || adv2;
  assign in_ready = adv1;

  // clamp hue and pick the sector, boundaries go to the lower sector
  always_comb begin
    hue_c = (in_pix.hue > hsvrgb_pkg::HueMax) ? hsvrgb_pkg::HueMax : in_pix.hue;
    if (hue_c <= hsvrgb_pkg::SectorDeg) begin
      sector_next = hsvrgb_pkg::SEC_RG;
      offset_next = hue_c;
    end else if (hue_c <= 9'(2 * hsvrgb_pkg::SectorDeg)) begin
      sector_next = hsvrgb_pkg::SEC_GR;
      offset_next = 9'(2 * hsvrgb_pkg::SectorDeg) - hue_c;
    end else if (hue_c <= 9'(3 * hsvrgb_pkg::SectorDeg)) begin
      sector_next = hsvrgb_pkg::SEC_GB;
      offset_next = hue_c - 9'(2 * hsvrgb_pkg::SectorDeg);
    end else if (hue_c <= 9'(4 * hsvrgb_pkg::SectorDeg)) begin
      sector_next = hsvrgb_pkg::SEC_BG;
      offset_next = 9'(4 * hsvrgb_pkg::SectorDeg) - hue_c;
    end else if (hue_c <= 9'(5 * hsvrgb_pkg::SectorDeg)) begin
      sector_next = hsvrgb_pkg::SEC_BR;
      offset_next = hue_c - 9'(4 * hsvrgb_pkg::SectorDeg);
    end else begin
      sector_next = hsvrgb_pkg::SEC_RB;
      offset_next = hsvrgb_pkg::HueMax - hue_c;
    end
  end

  // floor(x/255) = ((x+1)*257) >> 16 for any 16-bit x
  assign prod_inc    = {1'b0, product1} + 17'd1;
  assign prod_scaled = {prod_inc, 8'd0} + {8'd0, prod_inc};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      if (adv1) valid1 <= in_valid;
      if (adv2) valid2 <= valid1;
    end
    if (adv1 && in_valid) begin
      sector1     <= sector_next;
      offset1     <= offset_next[5:0];
      brightness1 <= in_pix.brightness;
      product1    <= 16'(in_pix.saturation) * 16'(in_pix.brightness);
    end
    if (adv2 && valid1) begin
      stage2.sector     <= sector1;
      stage2.offset     <= offset1;
      stage2.brightness <= brightness1;
      stage2.spread     <= prod_scaled[23:16];
    end
  end

  assign out_valid = valid2;
  assign out_pix   = stage2;

endmodule

>>> rtl/hsvrgb_ramp.sv
// stages three and four: offset*spread product, then divide by 60 via reciprocal
module hsvrgb_ramp (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsvrgb_pkg::front_t  in_pix,
  output logic                out_valid,
  input  logic                out_ready,
  output hsvrgb_pkg::ramp_t   out_pix
);

  logic        valid3;
  logic        valid4;
  logic        adv3;
  logic        adv4;
  logic [2:0]  sector3;
  logic [7:0]  brightness3;
  logic [7:0]  base3;
  logic [13:0] mult3;
  logic [28:0] recip_prod;
  hsvrgb_pkg::ramp_t stage4;

  assign adv4     = !valid4 || out_ready;
  assign adv3     = !valid3 || adv4;
  assign in_ready = adv3;

  assign recip_prod = 29'(mult3) * 29'(hsvrgb_pkg::Recip60);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else begin
      if (adv3) valid3 <= in_valid;
      if (adv4) valid4 <= valid3;
    end
    if (adv3 && in_valid) begin
      sector3     <= in_pix.sector;
      brightness3 <= in_pix.brightness;
      base3       <= in_pix.brightness - in_pix.spread;
      mult3       <= 14'(in_pix.offset) * 14'(in_pix.spread);
    end
    if (adv4 && valid3) begin
      stage4.sector     <= sector3;
      stage4.brightness <= brightness3;
      stage4.base_level <= base3;
      stage4.step       <= recip_prod[hsvrgb_pkg::Recip60Shift +: 8];
    end
  end

  assign out_valid = valid4;
  assign out_pix   = stage4;

endmodule

>>> rtl/hsv_to_rgb_converter_core.sv
// top level of the hsv to rgb converter: five-stage pipeline with registered output
// throughput: one pixel per cycle while rgb is ready, as every stage takes a new pixel each cycle
// a stall on rgb backs up stage by stage; bubbles in the pipe are squeezed out
// reset (synchronous, active high) clears all stage valid bits; no payload is cleared
module hsv_to_rgb_converter_core (
  input  logic        clk,
  input  logic        rst,
  hsvrgb_hsv_if.sink  hsv,
  hsvrgb_rgb_if.source rgb
);

  hsvrgb_pkg::hsv_t   in_pix;
  hsvrgb_pkg::front_t front_pix;
  hsvrgb_pkg::ramp_t  ramp_pix;

  logic       front_valid;
  logic       front_ready;
  logic       ramp_valid;
  logic       ramp_ready;
  logic       valid5;
  logic       adv5;
  logic [7:0] ramp_level;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  assign in_pix.hue        = hsv.hue;
  assign in_pix.saturation = hsv.saturation;
  assign in_pix.brightness = hsv.brightness;

  // stages one and two: sector, product, spread
  hsvrgb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsv.valid),
    .in_ready  (hsv.ready),
    .in_pix    (in_pix),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_pix   (front_pix)
  );

  // stages three and four: ramp step = offset*spread/60
  hsvrgb_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_pix    (front_pix),
    .out_valid (ramp_valid),
    .out_ready (ramp_ready),
    .out_pix   (ramp_pix)
  );

  // output stage takes a new pixel when empty or when the current one transfers
  assign adv5       = !valid5 || rgb.ready;
  assign ramp_ready = adv5;

  // ramping channel never exceeds brightness, so 8 bits hold it
  assign ramp_level = ramp_pix.base_level + ramp_pix.step;

  // route full level, floor and ramp to the channels by sector
  always_comb begin
    unique case (ramp_pix.sector)
      hsvrgb_pkg::SEC_RG: begin
        red_next   = ramp_pix.brightness;
        green_next = ramp_level;
        blue_next  = ramp_pix.base_level;
      end
      hsvrgb_pkg::SEC_GR: begin
        red_next   = ramp_level;
        green_next = ramp_pix.brightness;
        blue_next  = ramp_pix.base_level;
      end
      hsvrgb_pkg::SEC_GB: begin
        red_next   = ramp_pix.base_level;
        green_next = ramp_pix.brightness;
        blue_next  = ramp_level;
      end
      hsvrgb_pkg::SEC_BG: begin
        red_next   = ramp_pix.base_level;
        green_next = ramp_level;
        blue_next  = ramp_pix.brightness;
      end
      hsvrgb_pkg::SEC_BR: begin
        red_next   = ramp_level;
        green_next = ramp_pix.base_level;
        blue_next  = ramp_pix.brightness;
      end
      hsvrgb_pkg::SEC_RB: begin
        red_next   = ramp_pix.brightness;
        green_next = ramp_pix.base_level;
        blue_next  = ramp_level;
      end
      default: begin
        red_next   = ramp_pix.brightness;
        green_next = ramp_pix.base_level;
        blue_next  = ramp_pix.base_level;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid5 <= 1'b0;
    end else if (adv5) begin
      valid5 <= ramp_valid;
    end
    if (adv5 && ramp_valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign rgb.valid = valid5;
  assign rgb.red   = red;
  assign rgb.green = green;
  assign rgb.blue  = blue;

  // pipeline comes out of reset empty
  assert property (@(posedge clk) rst |=> !rgb.valid)
    else $error("rgb valid after reset");

  // reciprocal divide must keep the ramp at or below brightness
  assert property (@(posedge clk) disable iff (rst)
    ramp_valid |-> ({1'b0, ramp_pix.base_level} + {1'b0, ramp_pix.step}
                    <= {1'b0, ramp_pix.brightness}))
    else $error("ramp step exceeds spread");

  // an empty output stage means the whole pipe can take a pixel
  assert property (@(posedge clk) disable iff (rst) !rgb.valid |-> hsv.ready)
    else $error("input stalled with empty output stage");

endmodule
